/* hw/rtl/dpss_pkg.sv */
// Shared types, constants and pattern tables for the drum pattern step sequencer.
// No dependencies; imported by dpss_step_decode and drum_pattern_step_sequencer.
package dpss_pkg;

    localparam int LOOP_STEPS      = 32;
    localparam int BAR_STEPS       = 16;
    localparam int RHYTHM_COUNT    = 6;
    localparam int PHASE_FRAC_BITS = 8;

    localparam int STEP_W   = 5;
    localparam int PHASE_W  = 24;
    localparam int SUM_W    = PHASE_W + 1;
    localparam int RSEL_W   = 3;
    localparam int CFG_W    = 24;
    localparam int BAR_W    = $clog2(BAR_STEPS);

    localparam logic [SUM_W-1:0]   PHASE_ONE      = SUM_W'(1) << PHASE_FRAC_BITS;
    localparam logic [PHASE_W-1:0] PERIOD_RESET   = 24'd1536000;
    localparam logic [6:0]         DEFAULT_ROOT   = 7'd45;
    localparam logic [3:0]         NO_BASS        = 4'd8;

    typedef enum logic [2:0] {
        CMD_TICK          = 3'd0,
        CMD_SYNCHRO       = 3'd1,
        CMD_SPLIT_NOTE_ON = 3'd2,
        CMD_START         = 3'd3,
        CMD_STOP          = 3'd4,
        CMD_SPLIT_RELEASE = 3'd5,
        CMD_FILL_LEVEL    = 3'd6
    } command_t;

    typedef enum logic [1:0] {
        TR_STOPPED = 2'd0,
        TR_ARMED   = 2'd1,
        TR_PLAYING = 2'd2
    } transport_t;

    typedef enum logic [1:0] {
        FILL_NORMAL = 2'd0,
        FILL_KICKS  = 2'd1,
        FILL_SNARES = 2'd2
    } fill_t;

    // register indexes on the configuration port
    localparam logic REG_RHYTHM_SELECT = 1'b0;
    localparam logic REG_STEP_PERIOD   = 1'b1;

    typedef struct packed {
        logic       kick;
        logic       snare;
        logic       hat_open;
        logic       hat_closed;
        logic       bass;
        logic [7:0] note;
    } fire_t;

    localparam logic [31:0] KICK_ROWS [RHYTHM_COUNT] = '{
        32'h41041041, 32'h00010001, 32'h09010901,
        32'h01010101, 32'h04410441, 32'h41410141 };
    localparam logic [31:0] SNARE_ROWS [RHYTHM_COUNT] = '{
        32'h04104104, 32'h01100110, 32'h10101010,
        32'h10101010, 32'h90101010, 32'h10101010 };
    localparam logic [31:0] CLOSED_ROWS [RHYTHM_COUNT] = '{
        32'h55555555, 32'h01110111, 32'h92499249,
        32'h55555555, 32'hFFFFFFFF, 32'h55555555 };
    localparam logic [31:0] OPEN_ROWS [RHYTHM_COUNT] = '{
        32'h00000000, 32'h00000000, 32'h40000000,
        32'h40000000, 32'h00000000, 32'h40004000 };

    // bass offset per step, 8 = no bass note on that step
    localparam logic [3:0] BASS_ROWS [RHYTHM_COUNT][32] = '{
        '{0,8,8,8,8,8,7,8, 8,8,8,8,5,8,8,8, 8,8,3,8,8,8,8,8, 0,8,8,8,8,8,7,8},
        '{0,8,8,8,7,8,8,8, 7,8,8,8,8,8,8,8, 0,8,8,8,7,8,8,8, 7,8,8,8,8,8,8,8},
        '{0,8,8,8,3,8,8,8, 5,8,8,8,7,8,8,8, 0,8,8,8,3,8,8,8, 5,8,8,8,7,8,8,8},
        '{0,8,8,8,0,8,8,8, 7,8,8,8,5,8,8,8, 0,8,8,8,0,8,8,8, 7,8,8,8,3,8,8,8},
        '{0,8,8,8,8,8,7,8, 0,8,8,8,5,8,8,8, 0,8,8,8,8,8,7,8, 0,8,8,8,5,8,3,8},
        '{0,8,0,8,7,8,0,8, 0,8,3,8,7,8,5,8, 0,8,0,8,7,8,0,8, 0,8,3,8,5,8,3,8} };

    // Pattern ROM byte: bit0 kick, bit1 snare, bit2 closed hat, bit3 open hat,
    // bit4 bass valid, bits 7..5 bass offset. Empty for unused rhythm codes.
    function automatic logic [7:0] rom_entry(input logic [RSEL_W-1:0] r,
                                             input logic [STEP_W-1:0] s);
        logic [3:0] off;
        logic [7:0] e;
        off = NO_BASS;
        e   = '0;
        if (r < RSEL_W'(RHYTHM_COUNT))
        begin
            off  = BASS_ROWS[r][s];
            e[0] = KICK_ROWS[r][s];
            e[1] = SNARE_ROWS[r][s];
            e[2] = CLOSED_ROWS[r][s];
            e[3] = OPEN_ROWS[r][s];
            if (off < NO_BASS)
            begin
                e[4]   = 1'b1;
                e[7:5] = off[2:0];
            end
        end
        return e;
    endfunction

endpackage

/* hw/rtl/dpss_cmd_if.sv */
// Command channel: valid/ready handshake carrying one command beat.
// No dependencies.
interface dpss_cmd_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic              fill_button;
    logic signed [7:0] chord_root;

    modport source (output valid, output command, output fill_button, output chord_root,
                    input ready);
    modport sink   (input valid, input command, input fill_button, input chord_root,
                    output ready);
endinterface

/* hw/rtl/dpss_res_if.sv */
// Result channel: valid/ready handshake carrying triggers and status per beat.
// No dependencies.
interface dpss_res_if;
    logic       valid;
    logic       ready;
    logic       kick_fire;
    logic       snare_fire;
    logic       hat_open_fire;
    logic       hat_closed_fire;
    logic       bass_fire;
    logic [7:0] bass_note;
    logic [4:0] step_index;
    logic [1:0] transport_state;
    logic [1:0] fill_state;

    modport source (output valid, output kick_fire, output snare_fire,
                    output hat_open_fire, output hat_closed_fire, output bass_fire,
                    output bass_note, output step_index, output transport_state,
                    output fill_state, input ready);
    modport sink   (input valid, input kick_fire, input snare_fire,
                    input hat_open_fire, input hat_closed_fire, input bass_fire,
                    input bass_note, input step_index, input transport_state,
                    input fill_state, output ready);
endinterface

/* hw/rtl/dpss_step_decode.sv */
// Step decode: pattern ROM lookup, fill overrides, hat priority and bass note.
// Depends on dpss_pkg.
module dpss_step_decode
(
    input  logic [dpss_pkg::RSEL_W-1:0] rhythm,
    input  logic [dpss_pkg::STEP_W-1:0] step,
    input  dpss_pkg::fill_t             fill_mode,
    input  logic signed [7:0]           root,
    output dpss_pkg::fire_t             fire
);
    import dpss_pkg::*;

    logic [7:0] entry;
    logic [6:0] root_note;

    assign entry     = rom_entry(rhythm, step);
    assign root_note = root[7] ? DEFAULT_ROOT : root[6:0];

    always_comb
    begin
        fire.kick       = (fill_mode == FILL_KICKS)  ? (step[1:0] == 2'b00) : entry[0];
        fire.snare      = (fill_mode == FILL_SNARES) ? (step[0] == 1'b0)    : entry[1];
        fire.hat_open   = entry[3];
        fire.hat_closed = entry[2] & ~entry[3];
        fire.bass       = entry[4];
        fire.note       = entry[4] ? ({1'b0, root_note} + {5'b0, entry[7:5]}) : 8'd0;
    end

endmodule

/* hw/rtl/drum_pattern_step_sequencer.sv */
// Drum pattern step sequencer top level: command register, transport/fill state,
// phase accumulator, step decode and result register. Depends on dpss_pkg,
// dpss_cmd_if, dpss_res_if and dpss_step_decode.
// A command beat is held in the command register, then in the result register.
// Throughput: one beat per cycle unless res.ready holds a full result register;
// set by the state update between the registers. Reset: transport stopped, phase,
// step and fill state cleared, rhythm 0, step period 1536000 (6000.0 samples).
module drum_pattern_step_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [dpss_pkg::CFG_W-1:0]  cfg_data,
    dpss_cmd_if.sink                    cmd,
    dpss_res_if.source                  res
);
    import dpss_pkg::*;

    // ---------------- configuration registers ----------------
    logic [RSEL_W-1:0]  rhythm_reg;
    logic [PHASE_W-1:0] period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rhythm_reg <= '0;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_RHYTHM_SELECT)
                rhythm_reg <= cfg_data[RSEL_W-1:0];
            else
                period_reg <= cfg_data[PHASE_W-1:0];
        end
    end

    // ---------------- command register ----------------
    // Holds one accepted beat; refilled in the same cycle it is consumed.
    logic              in_vld_reg;
    logic [2:0]        cmd_reg;
    logic              btn_reg;
    logic signed [7:0] root_reg;
    logic              out_vld_reg;
    logic              advance;

    assign advance   = in_vld_reg & (~out_vld_reg | res.ready);
    assign cmd.ready = ~in_vld_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (cmd.ready)
            in_vld_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg  <= cmd.command;
            btn_reg  <= cmd.fill_button;
            root_reg <= cmd.chord_root;
        end
    end

    // ---------------- sequencer state ----------------
    transport_t         transport_reg, transport_next;
    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic [STEP_W-1:0]  step_reg,      step_next;
    fill_t              fill_reg,      fill_next;
    logic               prev_lvl_reg,  prev_lvl_next;
    logic               ret_pend_reg,  ret_pend_next;
    logic               fire_en;
    logic [SUM_W-1:0]   sum;
    fire_t              dec_fire;
    fire_t              fire;

    always_comb
    begin
        transport_next = transport_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        fill_next      = fill_reg;
        prev_lvl_next  = prev_lvl_reg;
        ret_pend_next  = ret_pend_reg;
        fire_en        = 1'b0;
        sum            = {1'b0, phase_reg} + PHASE_ONE;

        unique case (command_t'(cmd_reg))
            CMD_TICK:
            begin
                if (transport_reg == TR_PLAYING)
                begin
                    // at most one step per tick; excess phase carries over
                    if (sum >= {1'b0, period_reg})
                    begin
                        sum = sum - {1'b0, period_reg};
                        step_next = (step_reg == STEP_W'(LOOP_STEPS - 1)) ? '0
                                                                            : step_reg + 1'b1;
                        // bar line: pending fill return takes effect once released
                        if (step_next[BAR_W-1:0] == '0 && ret_pend_reg && !prev_lvl_reg)
                        begin
                            fill_next     = FILL_NORMAL;
                            ret_pend_next = 1'b0;
                        end
                        fire_en = 1'b1;
                    end
                    phase_next = sum[PHASE_W] ? '1 : sum[PHASE_W-1:0];
                end
            end
            CMD_SYNCHRO:
            begin
                if (transport_reg == TR_STOPPED)
                    transport_next = TR_ARMED;
            end
            CMD_SPLIT_NOTE_ON, CMD_START:
            begin
                // split note only restarts when not already playing
                if (cmd_reg == CMD_START || transport_reg != TR_PLAYING)
                begin
                    transport_next = TR_PLAYING;
                    step_next      = '0;
                    phase_next     = '0;
                    fire_en        = 1'b1;
                end
            end
            CMD_STOP:
                transport_next = TR_STOPPED;
            CMD_SPLIT_RELEASE:
            begin
                if (transport_reg == TR_ARMED)
                    transport_next = TR_STOPPED;
            end
            CMD_FILL_LEVEL:
            begin
                if (btn_reg && !prev_lvl_reg)
                begin
                    fill_next     = (fill_reg == FILL_KICKS) ? FILL_SNARES : FILL_KICKS;
                    ret_pend_next = 1'b0;
                end
                else if (!btn_reg && prev_lvl_reg)
                    ret_pend_next = 1'b1;
                prev_lvl_next = btn_reg;
            end
            default:
            begin
                // unused code: state reported unchanged, nothing fires
            end
        endcase
    end

    // decode sees the step and fill mode as they stand after this beat
    dpss_step_decode u_decode
    (
        .rhythm    (rhythm_reg),
        .step      (step_next),
        .fill_mode (fill_next),
        .root      (root_reg),
        .fire      (dec_fire)
    );

    assign fire = fire_en ? dec_fire : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transport_reg <= TR_STOPPED;
            phase_reg     <= '0;
            step_reg      <= '0;
            fill_reg      <= FILL_NORMAL;
            prev_lvl_reg  <= 1'b0;
            ret_pend_reg  <= 1'b0;
        end
        else if (advance)
        begin
            transport_reg <= transport_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            fill_reg      <= fill_next;
            prev_lvl_reg  <= prev_lvl_next;
            ret_pend_reg  <= ret_pend_next;
        end
    end

    // ---------------- result register ----------------
    fire_t              fire_out_reg;
    logic [STEP_W-1:0]  step_out_reg;
    transport_t         transport_out_reg;
    fill_t              fill_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (res.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fire_out_reg      <= fire;
            step_out_reg      <= step_next;
            transport_out_reg <= transport_next;
            fill_out_reg      <= fill_next;
        end
    end

    assign res.valid           = out_vld_reg;
    assign res.kick_fire       = fire_out_reg.kick;
    assign res.snare_fire      = fire_out_reg.snare;
    assign res.hat_open_fire   = fire_out_reg.hat_open;
    assign res.hat_closed_fire = fire_out_reg.hat_closed;
    assign res.bass_fire       = fire_out_reg.bass;
    assign res.bass_note       = fire_out_reg.note;
    assign res.step_index      = step_out_reg;
    assign res.transport_state = transport_out_reg;
    assign res.fill_state      = fill_out_reg;

    // ---------------- assertions ----------------
    // open hat wins over closed hat
    a_hat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.hat_open_fire && res.hat_closed_fire))
        else $error("open and closed hat fired together");

    // a bass note number only travels with a bass trigger
    a_note_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.bass_fire) |-> (res.bass_note == 8'd0))
        else $error("bass note without bass trigger");

    // triggers only come while playing
    a_fire_play: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kick_fire || res.snare_fire || res.hat_open_fire
                       || res.hat_closed_fire || res.bass_fire))
        |-> (res.transport_state == TR_PLAYING))
        else $error("trigger while not playing");

    // step counter moves only when a beat is processed
    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(step_reg))
        else $error("step counter moved without a beat");

endmodule
